@@ rtl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define PNG_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PNG_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/pngenc_pkg.sv @@
package pngenc_pkg;

  localparam int unsigned DIM_W      = 14;
  localparam int unsigned ROWB_W     = 16;
  localparam int unsigned TOTAL_W    = 30;
  localparam int unsigned BLOCK_W    = 16;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = 2;
  localparam int unsigned FIFO_CNT_W = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;

  localparam logic [31:0] CRC_POLY        = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT        = 32'hFFFFFFFF;
  localparam logic [16:0] ADLER_MOD       = 17'd65521;
  localparam logic [29:0] BLK_PAYLOAD_MAX = 30'd65535;
  localparam logic [63:0] PNG_SIG         = 64'h89504E470D0A1A0A;
  localparam logic [31:0] TAG_IHDR        = 32'h49484452;
  localparam logic [31:0] TAG_IDAT        = 32'h49444154;
  localparam logic [31:0] TAG_IEND        = 32'h49454E44;
  localparam logic [7:0]  ZLIB_CMF        = 8'h78;
  localparam logic [7:0]  ZLIB_FLG        = 8'h01;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       row_start;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [TOTAL_W-1:0] total;
    logic [31:0]        idat_size;
    logic               started;
  } geom_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ rtl/uncompressed_png_rgb_stream_encoder.sv @@
// path: an accepted pixel byte passes the item queue and the output byte register;
// an image's first pixel byte sets off 43 header bytes, its last is trailed by 20 more
// throughput: one output byte per cycle, set by the single output byte register, while
// the receiver is ready; a row start adds a filter byte, a stored block boundary 5 bytes
// reset: asynchronous, active low; idle, 1x1 geometry, no clearing pass
`include "assert_macros.svh"

module uncompressed_png_rgb_stream_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pngenc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pngenc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [7:0]                           pixel_byte_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [7:0]                           out_byte_o,
  output logic                                 last_of_run_o,
  output logic                                 end_of_image_o
);

  pngenc_pkg::item_t  item, head;
  pngenc_pkg::geom_t  geom;
  logic               in_accept, q_full, q_valid, q_pop, cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = !q_full;
  assign in_accept   = in_valid_i && in_ready_o;

  pngenc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_write_i  (cfg_write),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_accept_i  (in_accept),
    .pixel_byte_i (pixel_byte_i),
    .item_o       (item),
    .geom_o       (geom)
  );

  pngenc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_accept),
    .push_item_i (item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .head_o      (head)
  );

  pngenc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .head_i         (head),
    .q_pop_o        (q_pop),
    .geom_i         (geom),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .last_of_run_o  (last_of_run_o),
    .end_of_image_o (end_of_image_o)
  );

  `PNG_ASSERT(a_eoi_ends_run, clk_i, rst_ni, out_valid_o && end_of_image_o |-> last_of_run_o, "end of image without end of run")
  `PNG_ASSERT(a_geom_frozen, clk_i, rst_ni, geom.started && cfg_write |=> $stable(geom.width) && $stable(geom.height), "geometry changed mid image")
  `PNG_ASSERT_ALWAYS(a_pop_nonempty, clk_i, q_pop |-> q_valid, "item queue popped while empty")

endmodule

@@ rtl/pngenc_fifo.sv @@
module pngenc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  pngenc_pkg::item_t   push_item_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output pngenc_pkg::item_t   head_o
);

  pngenc_pkg::item_t                         mem_q [pngenc_pkg::FIFO_DEPTH];
  logic [pngenc_pkg::FIFO_PTR_W-1:0]         wr_q, rd_q;
  logic [pngenc_pkg::FIFO_CNT_W-1:0]         cnt_q;

  assign full_o  = (cnt_q == pngenc_pkg::FIFO_CNT_W'(pngenc_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ rtl/pngenc_front.sv @@
module pngenc_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_write_i,
  input  logic [pngenc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pngenc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                 in_accept_i,
  input  logic [7:0]                           pixel_byte_i,
  output pngenc_pkg::item_t                    item_o,
  output pngenc_pkg::geom_t                    geom_o
);

  logic [pngenc_pkg::DIM_W-1:0]   width_q, height_q, w_eff, h_eff;
  logic [pngenc_pkg::ROWB_W-1:0]  col_q, col_inc, row_len;
  logic [pngenc_pkg::DIM_W-1:0]   row_q;
  logic [pngenc_pkg::DIM_W:0]     row_inc;
  logic                           started_q, end_row, end_img;
  logic [pngenc_pkg::TOTAL_W-1:0] total_q;
  logic [30:0]                    ceil_arg;
  logic [14:0]                    q0;
  logic [16:0]                    rem;
  logic [14:0]                    blocks_q;
  logic [pngenc_pkg::TOTAL_W-1:0] total2_q;
  logic [31:0]                    idat_q;

  assign w_eff     = (width_q == '0) ? pngenc_pkg::DIM_W'(1) : width_q;
  assign h_eff     = (height_q == '0) ? pngenc_pkg::DIM_W'(1) : height_q;
  assign row_len   = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
  assign col_inc   = col_q + 1'b1;
  assign row_inc   = {1'b0, row_q} + 1'b1;
  assign end_row   = (col_inc >= row_len);
  assign end_img   = end_row && (row_inc >= {1'b0, h_eff});

  assign item_o.data      = pixel_byte_i;
  assign item_o.first     = !started_q;
  assign item_o.row_start = (col_q == '0);
  assign item_o.last      = end_img;

  // ceil(total / 65535) as floor((total + 65534) / 65535), one correction step
  assign ceil_arg = {1'b0, total_q} + 31'd65534;
  assign q0       = ceil_arg[30:16];
  assign rem      = {1'b0, ceil_arg[15:0]} + {2'b00, q0};

  assign geom_o.width     = w_eff;
  assign geom_o.height    = h_eff;
  assign geom_o.total     = total2_q;
  assign geom_o.idat_size = idat_q;
  assign geom_o.started   = started_q;

  always_ff @(posedge clk_i) begin
    total_q  <= pngenc_pkg::TOTAL_W'(h_eff * (row_len + 1'b1));
    blocks_q <= q0 + 15'(rem >= 17'd65535);
    total2_q <= total_q;
    idat_q   <= 32'(blocks_q) * 32'd5 + 32'(total2_q) + 32'd6;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= pngenc_pkg::DIM_W'(1);
      height_q  <= pngenc_pkg::DIM_W'(1);
      col_q     <= '0;
      row_q     <= '0;
      started_q <= 1'b0;
    end else begin
      // geometry is frozen while an image is under way
      if (cfg_write_i && !started_q) begin
        if (cfg_index_i == pngenc_pkg::REG_WIDTH) begin
          width_q <= cfg_data_i[pngenc_pkg::DIM_W-1:0];
        end else if (cfg_index_i == pngenc_pkg::REG_HEIGHT) begin
          height_q <= cfg_data_i[pngenc_pkg::DIM_W-1:0];
        end
      end
      if (in_accept_i) begin
        if (end_img) begin
          col_q     <= '0;
          row_q     <= '0;
          started_q <= 1'b0;
        end else begin
          started_q <= 1'b1;
          if (end_row) begin
            col_q <= '0;
            row_q <= row_inc[pngenc_pkg::DIM_W-1:0];
          end else begin
            col_q <= col_inc;
          end
        end
      end
    end
  end

endmodule

@@ rtl/pngenc_back.sv @@
module pngenc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  pngenc_pkg::item_t   head_i,
  output logic                q_pop_o,
  input  pngenc_pkg::geom_t   geom_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                last_of_run_o,
  output logic                end_of_image_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_HDR  = 3'd1;
  localparam logic [2:0] ST_BLK  = 3'd2;
  localparam logic [2:0] ST_DAT  = 3'd3;
  localparam logic [2:0] ST_TRL  = 3'd4;

  localparam logic [5:0] HDR_LAST    = 6'd42;
  localparam logic [5:0] HDR_CRC_END = 6'd32;
  localparam logic [5:0] BLK_LAST    = 6'd4;
  localparam logic [5:0] TRL_CRC_END = 6'd7;
  localparam logic [5:0] TRL_LAST    = 6'd19;

  logic [2:0]                      st_q, st_d;
  logic [5:0]                      idx_q, idx_d;
  logic                            filt_q, filt_d, filt_eff;
  logic [pngenc_pkg::BLOCK_W-1:0]  blk_q, blk_d, payload;
  logic [pngenc_pkg::TOTAL_W-1:0]  fbl_q, fbl_d;
  logic [15:0]                     alo_q, alo_d, ahi_q, ahi_d;
  logic [31:0]                     crc_q, crc_d;
  logic                            ov_q, ob_last_q, ob_eoi_q;
  logic [7:0]                      ob_q;
  logic                            can_emit, emit, use_crc, clr_crc, e_last, e_eoi;
  logic                            adl_upd, adl_clr, bfinal;
  logic [7:0]                      e_byte, hdr_b;
  logic [16:0]                     lo_sum, hi_sum;
  logic [15:0]                     lo_new, hi_new;
  logic [1:0]                      sel_off;

  function automatic logic [7:0] be_byte(input logic [31:0] v, input logic [1:0] sel);
    return v[8*(3-sel) +: 8];
  endfunction

  assign can_emit = !ov_q || out_ready_i;
  assign filt_eff = (st_q == ST_IDLE) ? head_i.row_start : filt_q;
  assign payload  = (fbl_q > pngenc_pkg::BLK_PAYLOAD_MAX) ? 16'hFFFF : fbl_q[15:0];
  assign bfinal   = (fbl_q <= pngenc_pkg::BLK_PAYLOAD_MAX);
  assign sel_off  = idx_q[1:0] - 2'd1;

  // header bytes, sequenced by position
  always_comb begin
    hdr_b = 8'h00;
    if (idx_q < 6'd8) begin
      hdr_b = pngenc_pkg::PNG_SIG[8*(7-idx_q[2:0]) +: 8];
    end else if (idx_q < 6'd12) begin
      hdr_b = be_byte(32'd13, idx_q[1:0]);
    end else if (idx_q < 6'd16) begin
      hdr_b = be_byte(pngenc_pkg::TAG_IHDR, idx_q[1:0]);
    end else if (idx_q < 6'd20) begin
      hdr_b = be_byte(32'(geom_i.width), idx_q[1:0]);
    end else if (idx_q < 6'd24) begin
      hdr_b = be_byte(32'(geom_i.height), idx_q[1:0]);
    end else if (idx_q == 6'd24) begin
      hdr_b = 8'd8;
    end else if (idx_q == 6'd25) begin
      hdr_b = 8'd2;
    end else if (idx_q < 6'd29) begin
      hdr_b = 8'd0;
    end else if (idx_q < 6'd33) begin
      hdr_b = be_byte(~crc_q, sel_off);
    end else if (idx_q < 6'd37) begin
      hdr_b = be_byte(geom_i.idat_size, sel_off);
    end else if (idx_q < 6'd41) begin
      hdr_b = be_byte(pngenc_pkg::TAG_IDAT, sel_off);
    end else if (idx_q == 6'd41) begin
      hdr_b = pngenc_pkg::ZLIB_CMF;
    end else begin
      hdr_b = pngenc_pkg::ZLIB_FLG;
    end
  end

  always_comb begin
    st_d    = st_q;
    idx_d   = idx_q;
    filt_d  = filt_q;
    blk_d   = blk_q;
    fbl_d   = fbl_q;
    emit    = 1'b0;
    use_crc = 1'b0;
    clr_crc = 1'b0;
    e_last  = 1'b0;
    e_eoi   = 1'b0;
    e_byte  = 8'h00;
    adl_upd = 1'b0;
    adl_clr = 1'b0;
    q_pop_o = 1'b0;
    if (can_emit) begin
      priority if (st_q == ST_IDLE && !q_valid_i) begin
        emit = 1'b0;
      end else if (st_q == ST_IDLE && head_i.first) begin
        emit    = 1'b1;
        e_byte  = hdr_b;
        clr_crc = 1'b1;
        st_d    = ST_HDR;
        idx_d   = 6'd1;
        filt_d  = 1'b1;
      end else if (st_q == ST_IDLE || st_q == ST_DAT) begin
        emit    = 1'b1;
        use_crc = 1'b1;
        if (blk_q == '0) begin
          // stored block header: BFINAL, LEN, NLEN
          e_byte = {7'd0, bfinal};
          st_d   = ST_BLK;
          idx_d  = 6'd1;
          filt_d = filt_eff;
        end else begin
          e_byte  = filt_eff ? 8'h00 : head_i.data;
          adl_upd = 1'b1;
          blk_d   = blk_q - 1'b1;
          if (fbl_q != '0) fbl_d = fbl_q - 1'b1;
          if (filt_eff) begin
            filt_d = 1'b0;
            st_d   = ST_DAT;
          end else begin
            q_pop_o = 1'b1;
            if (head_i.last) begin
              st_d  = ST_TRL;
              idx_d = 6'd0;
            end else begin
              st_d   = ST_IDLE;
              e_last = 1'b1;
            end
          end
        end
      end else if (st_q == ST_HDR) begin
        emit   = 1'b1;
        e_byte = hdr_b;
        use_crc = ((idx_q >= 6'd12) && (idx_q < 6'd29)) || (idx_q >= 6'd37);
        clr_crc = (idx_q == HDR_CRC_END);
        idx_d  = idx_q + 1'b1;
        if (idx_q == HDR_LAST) begin
          st_d    = ST_DAT;
          fbl_d   = geom_i.total;
          blk_d   = '0;
          adl_clr = 1'b1;
        end
      end else if (st_q == ST_BLK) begin
        emit    = 1'b1;
        use_crc = 1'b1;
        unique case (idx_q[2:0])
          3'd1:    e_byte = payload[7:0];
          3'd2:    e_byte = payload[15:8];
          3'd3:    e_byte = ~payload[7:0];
          default: e_byte = ~payload[15:8];
        endcase
        idx_d = idx_q + 1'b1;
        if (idx_q == BLK_LAST) begin
          blk_d = payload;
          st_d  = ST_DAT;
        end
      end else begin
        // trailer: adler, idat crc, iend length, tag, crc
        emit  = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q < 6'd4) begin
          e_byte  = be_byte({ahi_q, alo_q}, idx_q[1:0]);
          use_crc = 1'b1;
        end else if (idx_q < 6'd8) begin
          e_byte  = be_byte(~crc_q, idx_q[1:0]);
          clr_crc = (idx_q == TRL_CRC_END);
        end else if (idx_q < 6'd12) begin
          e_byte = 8'h00;
        end else if (idx_q < 6'd16) begin
          e_byte  = be_byte(pngenc_pkg::TAG_IEND, idx_q[1:0]);
          use_crc = 1'b1;
        end else begin
          e_byte = be_byte(~crc_q, idx_q[1:0]);
          if (idx_q == TRL_LAST) begin
            clr_crc = 1'b1;
            adl_clr = 1'b1;
            e_last  = 1'b1;
            e_eoi   = 1'b1;
            st_d    = ST_IDLE;
            idx_d   = 6'd0;
            blk_d   = '0;
            fbl_d   = '0;
            filt_d  = 1'b0;
          end
        end
      end
    end
  end

  assign lo_sum = {1'b0, alo_q} + {9'd0, e_byte};
  assign lo_new = (lo_sum >= pngenc_pkg::ADLER_MOD) ? 16'(lo_sum - pngenc_pkg::ADLER_MOD)
                                                    : lo_sum[15:0];
  assign hi_sum = {1'b0, ahi_q} + {1'b0, lo_new};
  assign hi_new = (hi_sum >= pngenc_pkg::ADLER_MOD) ? 16'(hi_sum - pngenc_pkg::ADLER_MOD)
                                                    : hi_sum[15:0];

  always_comb begin
    alo_d = alo_q;
    ahi_d = ahi_q;
    if (adl_clr) begin
      alo_d = 16'd1;
      ahi_d = 16'd0;
    end else if (adl_upd) begin
      alo_d = lo_new;
      ahi_d = hi_new;
    end
    crc_d = crc_q;
    if (clr_crc) begin
      crc_d = pngenc_pkg::CRC_INIT;
    end else if (use_crc) begin
      crc_d = pngenc_pkg::crc_byte(crc_q, e_byte);
    end
  end

  assign out_valid_o    = ov_q;
  assign out_byte_o     = ob_q;
  assign last_of_run_o  = ob_last_q;
  assign end_of_image_o = ob_eoi_q;

  always_ff @(posedge clk_i) begin
    if (emit) begin
      ob_q      <= e_byte;
      ob_last_q <= e_last;
      ob_eoi_q  <= e_eoi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_IDLE;
      idx_q  <= '0;
      filt_q <= 1'b0;
      blk_q  <= '0;
      fbl_q  <= '0;
      alo_q  <= 16'd1;
      ahi_q  <= 16'd0;
      crc_q  <= pngenc_pkg::CRC_INIT;
      ov_q   <= 1'b0;
    end else begin
      st_q   <= st_d;
      idx_q  <= idx_d;
      filt_q <= filt_d;
      blk_q  <= blk_d;
      fbl_q  <= fbl_d;
      alo_q  <= alo_d;
      ahi_q  <= ahi_d;
      crc_q  <= crc_d;
      if (can_emit) ov_q <= emit;
    end
  end

endmodule

@@ verif/png_stream_checker.sv @@
`timescale 1ns / 100ps

module png_stream_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [pngenc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pngenc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [7:0]                        pixel_byte_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [7:0]                        out_byte_i,
  input  logic                              last_of_run_i,
  input  logic                              end_of_image_i,
  output int                                pending_o,
  output int                                errors_o
);

  localparam int unsigned BLOCK_LIMIT = 65535;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       eoi;
  } png_byte_t;

  png_byte_t png_bytes_q[$];

  logic [13:0] width_reg, height_reg;
  logic [15:0] col_cnt;
  logic [13:0] rows_done;
  logic [15:0] block_left;
  logic [29:0] data_left;
  logic [16:0] adler_a, adler_b;
  logic [31:0] crc_acc;
  logic        in_image;
  int          errors;

  assign pending_o = png_bytes_q.size();
  assign errors_o  = errors;

  function automatic logic [13:0] eff_dim(logic [13:0] v);
    return (v == 0) ? 14'd1 : v;
  endfunction

  function void emit(logic [7:0] b, bit with_crc);
    png_byte_t e;
    if (with_crc) begin
      crc_acc = crc_acc ^ {24'd0, b};
      for (int k = 0; k < 8; k++)
        crc_acc = crc_acc[0] ? (32'hEDB88320 ^ (crc_acc >> 1)) : (crc_acc >> 1);
    end
    e.data = b;
    e.last = 1'b0;
    e.eoi  = 1'b0;
    png_bytes_q.push_back(e);
  endfunction

  function void emit32(logic [31:0] v, bit with_crc);
    for (int i = 3; i >= 0; i--) emit(v[i*8 +: 8], with_crc);
  endfunction

  function void emit_crc();
    emit32(~crc_acc, 1'b0);
    crc_acc = '1;
  endfunction

  function void emit_filtered(logic [7:0] x);
    logic [29:0] payload;
    if (block_left == 0) begin
      payload = (data_left > BLOCK_LIMIT) ? BLOCK_LIMIT : data_left;
      emit((payload == data_left) ? 8'd1 : 8'd0, 1'b1);
      emit(payload[7:0], 1'b1);
      emit(payload[15:8], 1'b1);
      emit(~payload[7:0], 1'b1);
      emit(~payload[15:8], 1'b1);
      block_left = payload[15:0];
    end
    emit(x, 1'b1);
    adler_a = adler_a + x;
    if (adler_a >= 65521) adler_a = adler_a - 65521;
    adler_b = adler_b + adler_a;
    if (adler_b >= 65521) adler_b = adler_b - 65521;
    if (block_left != 0) block_left--;
    if (data_left != 0) data_left--;
  endfunction

  function void open_image();
    logic [13:0] w, h;
    logic [31:0] total;
    longint      blocks;
    logic [63:0] sig;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    total = h * (1 + 3 * w);
    blocks = (longint'(total) + BLOCK_LIMIT - 1) / BLOCK_LIMIT;
    sig = 64'h89504E470D0A1A0A;
    for (int i = 7; i >= 0; i--) emit(sig[i*8 +: 8], 1'b0);
    crc_acc = '1;
    emit32(32'd13, 1'b0);
    emit32(32'h49484452, 1'b1);
    emit32({18'd0, w}, 1'b1);
    emit32({18'd0, h}, 1'b1);
    emit(8'd8, 1'b1);
    emit(8'd2, 1'b1);
    emit(8'd0, 1'b1);
    emit(8'd0, 1'b1);
    emit(8'd0, 1'b1);
    emit_crc();
    emit32(32'(2 + 5 * blocks + total + 4), 1'b0);
    emit32(32'h49444154, 1'b1);
    emit(8'h78, 1'b1);
    emit(8'h01, 1'b1);
    data_left  = total[29:0];
    col_cnt    = 0;
    rows_done  = 0;
    block_left = 0;
    adler_a    = 1;
    adler_b    = 0;
    in_image   = 1'b1;
  endfunction

  function void clear_image();
    col_cnt    = 0;
    rows_done  = 0;
    block_left = 0;
    data_left  = 0;
    adler_a    = 1;
    adler_b    = 0;
    crc_acc    = '1;
    in_image   = 1'b0;
  endfunction

  function void predict_pixel(logic [7:0] px);
    bit ended;
    ended = 1'b0;
    if (!in_image) open_image();
    if (col_cnt == 0) emit_filtered(8'd0);
    emit_filtered(px);
    col_cnt++;
    if (col_cnt >= 3 * eff_dim(width_reg)) begin
      col_cnt = 0;
      rows_done++;
      if (rows_done >= eff_dim(height_reg)) begin
        emit32({adler_b[15:0], adler_a[15:0]}, 1'b1);
        emit_crc();
        emit32(32'd0, 1'b0);
        emit32(32'h49454E44, 1'b1);
        emit_crc();
        clear_image();
        ended = 1'b1;
      end
    end
    png_bytes_q[$].last = 1'b1;
    png_bytes_q[$].eoi  = ended;
  endfunction

  initial begin
    errors = 0;
    width_reg = 1;
    height_reg = 1;
    clear_image();
  end

  always @(posedge clk_i) begin
    png_byte_t exp_b;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i && !in_image) begin
        if (cfg_index_i == pngenc_pkg::REG_WIDTH) width_reg = cfg_data_i[13:0];
        else if (cfg_index_i == pngenc_pkg::REG_HEIGHT) height_reg = cfg_data_i[13:0];
      end
      if (in_valid_i && in_ready_i) predict_pixel(pixel_byte_i);
      if (out_valid_i && out_ready_i) begin
        if (png_bytes_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected output byte %02h", $time, out_byte_i);
        end else begin
          exp_b = png_bytes_q.pop_front();
          if (exp_b.data !== out_byte_i || exp_b.last !== last_of_run_i ||
              exp_b.eoi !== end_of_image_i) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch exp byte=%02h last=%b eoi=%b got byte=%02h last=%b eoi=%b",
                       $time, exp_b.data, exp_b.last, exp_b.eoi,
                       out_byte_i, last_of_run_i, end_of_image_i);
          end
        end
      end
    end
  end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  localparam logic [pngenc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 8'd7;
  localparam int CYCLE_LIMIT = 3000000;

  logic                              clk, rst_n;
  logic                              cfg_valid, cfg_ready;
  logic [pngenc_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [pngenc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                              in_valid, in_ready;
  logic [7:0]                        pixel_byte;
  logic                              out_valid, out_ready;
  logic [7:0]                        out_byte;
  logic                              last_of_run, end_of_image;
  int                                pending, errors, cycles, pixels_sent;
  bit                                no_idle, hold_req, hold_next;

  uncompressed_png_rgb_stream_encoder u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .pixel_byte_i(pixel_byte),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_byte_o(out_byte),
    .last_of_run_o(last_of_run), .end_of_image_o(end_of_image)
  );

  png_stream_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .pixel_byte_i(pixel_byte),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_byte_i(out_byte),
    .last_of_run_i(last_of_run), .end_of_image_i(end_of_image),
    .pending_o(pending), .errors_o(errors)
  );

  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = no_idle || ($urandom_range(99) >= 27);
      end
    end
  end

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(logic [pngenc_pkg::CFG_IDX_W-1:0] idx,
                           logic [pngenc_pkg::CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_pixel(logic [7:0] b);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 27) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    pixel_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic run_image(logic [pngenc_pkg::CFG_DATA_W-1:0] w,
                           logic [pngenc_pkg::CFG_DATA_W-1:0] h);
    int n;
    write_reg(pngenc_pkg::REG_WIDTH, w);
    write_reg(pngenc_pkg::REG_HEIGHT, h);
    // the receiver holds off while this image's items keep coming
    if (hold_next) begin
      hold_req  = 1'b1;
      hold_next = 1'b0;
    end
    n = 3 * (w == 0 ? 1 : w) * (h == 0 ? 1 : h);
    for (int i = 0; i < n; i++) send_pixel(8'($urandom_range(255)));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    pixel_byte = '0;
    cycles = 0;
    pixels_sent = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    hold_next = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset geometry is 1x1: pixel extremes
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hA5);
    @(negedge clk);
    in_valid = 1'b0;
    // zero dimensions act as one
    run_image(16'd0, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_image(16'd2, 16'd1);
    run_image(16'd1, 16'd3);

    // long receiver hold-off fills the queue and stalls the input
    hold_next = 1'b1;
    run_image(16'd4, 16'd2);

    // random small images with a stretch of no idling
    while (pixels_sent < 180) begin
      no_idle = (pixels_sent > 100 && pixels_sent < 160);
      run_image(16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)));
    end
    no_idle = 1'b0;

    run_image(16'd1, 16'd1);

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/pngenc_pkg.sv
rtl/pngenc_fifo.sv
rtl/pngenc_front.sv
rtl/pngenc_back.sv
rtl/uncompressed_png_rgb_stream_encoder.sv
verif/png_stream_checker.sv
verif/tb_top.sv
